FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks (gbn_proto).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GBN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define GBN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/gbn_pkg.sv
// Shared types and constants for the go-back-N receiver.
package gbn_pkg;

    localparam int unsigned SEQ_WIDTH_DEF    = 32;
    localparam int unsigned PKT_SEQ_W        = 32;
    localparam int unsigned PKT_DATA_W       = 32;
    localparam int unsigned CLOSE_W          = 16;
    localparam logic [CLOSE_W-1:0] CLOSE_WAIT_RESET = 16'd1000;

    // Stream packing widths
    localparam int unsigned IN_TDATA_W  = PKT_SEQ_W + PKT_DATA_W;
    localparam int unsigned IN_TUSER_W  = 4;
    localparam int unsigned OUT_TDATA_W = PKT_SEQ_W + PKT_DATA_W;
    localparam int unsigned OUT_TUSER_W = 5;

    typedef enum logic [2:0] {
        PKT_SYN   = 3'd0,
        PKT_ACK   = 3'd1,
        PKT_DATA  = 3'd2,
        PKT_FIN   = 3'd3,
        PKT_OTHER = 3'd4
    } t_frame_type;

    typedef enum logic [1:0] {
        RPL_SYN_ACK  = 2'd0,
        RPL_DATA_ACK = 2'd1,
        RPL_FIN_ACK  = 2'd2
    } t_reply_kind;

    typedef enum logic {
        OP_POLL   = 1'b0,
        OP_PACKET = 1'b1
    } t_op;

    typedef struct packed {
        logic                  op;
        logic [2:0]            frame_type;
        logic [PKT_SEQ_W-1:0]  pkt_seq;
        logic [PKT_DATA_W-1:0] pkt_data;
    } t_in_item;

    typedef struct packed {
        logic                  send_valid;
        logic [1:0]            reply_kind;
        logic [PKT_SEQ_W-1:0]  reply_seq;
        logic                  deliver_valid;
        logic [PKT_DATA_W-1:0] deliver_data;
        logic                  link_closed;
    } t_result;

endpackage

FILE: rtl/gbn_in_reg.sv
// Input register stage: captures one beat and hands it to the protocol logic.
module gbn_in_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tvalid,
    output logic                             o_tready,
    input  logic [gbn_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic [gbn_pkg::IN_TUSER_W-1:0]   i_tuser,
    input  logic                             i_advance,
    output logic                             o_fire,
    output gbn_pkg::t_in_item                o_item
);
    import gbn_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    // Take a beat when empty or when the held beat moves on this cycle
    assign o_tready = !r_valid || i_advance;
    assign w_accept = i_tvalid && o_tready;
    assign o_fire   = r_valid && i_advance;
    assign o_item   = r_item;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Unpack the beat; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op         <= i_tuser[0];
            r_item.frame_type <= i_tuser[3:1];
            r_item.pkt_seq    <= i_tdata[PKT_SEQ_W-1:0];
            r_item.pkt_data   <= i_tdata[IN_TDATA_W-1:PKT_SEQ_W];
        end
    end

endmodule

FILE: rtl/gbn_proto.sv
// Link state, close timer and the per-item reply/delivery decision.
`include "assert_macros.svh"

module gbn_proto #(
    parameter int unsigned SEQ_WIDTH = gbn_pkg::SEQ_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [gbn_pkg::CLOSE_W-1:0]   i_cfg_wdata,
    input  logic                          i_fire,
    input  gbn_pkg::t_in_item             i_item,
    output gbn_pkg::t_result              o_result
);
    import gbn_pkg::*;

    logic [CLOSE_W-1:0]   r_close_limit;
    logic [SEQ_WIDTH-1:0] r_last, n_last;
    logic [SEQ_WIDTH-1:0] r_expected, n_expected;
    logic                 r_syn_seen, n_syn_seen;
    logic                 r_link_up, n_link_up;
    logic                 r_fin_seen, n_fin_seen;
    logic [CLOSE_W-1:0]   r_close_count, n_close_count;
    logic                 r_closed, n_closed;

    logic [SEQ_WIDTH-1:0] w_seq;
    logic                 w_seq_zero;
    logic                 w_is_pkt;
    t_result              w_res;

    // Reduce the packet sequence to the link's sequence width
    assign w_seq      = SEQ_WIDTH'(i_item.pkt_seq);
    assign w_seq_zero = (w_seq == '0);
    assign w_is_pkt   = (i_item.op == OP_PACKET);

    always_comb begin
        n_last        = r_last;
        n_expected    = r_expected;
        n_syn_seen    = r_syn_seen;
        n_link_up     = r_link_up;
        n_fin_seen    = r_fin_seen;
        n_close_count = r_close_count;
        n_closed      = r_closed;
        w_res         = '0;

        if (r_closed) begin
            // Closed: ignore the item, report closure only
            w_res.link_closed = 1'b1;
        end else begin
            // Count items after FIN, saturating
            if (r_fin_seen) begin
                if (r_close_count != '1) begin
                    n_close_count = r_close_count + CLOSE_W'(1);
                end
                if (n_close_count > r_close_limit) begin
                    n_closed = 1'b1;
                end
            end

            if (w_is_pkt) begin
                if (i_item.frame_type == PKT_SYN && w_seq_zero) begin
                    w_res.send_valid = 1'b1;
                    w_res.reply_kind = RPL_SYN_ACK;
                    w_res.reply_seq  = PKT_SEQ_W'(r_last);
                    n_syn_seen       = 1'b1;
                end else if (i_item.frame_type == PKT_ACK && w_seq_zero) begin
                    n_last     = '0;
                    n_expected = SEQ_WIDTH'(1);
                    n_link_up  = 1'b1;
                end else if (i_item.frame_type == PKT_DATA && !w_seq_zero && r_link_up) begin
                    w_res.send_valid = 1'b1;
                    w_res.reply_kind = RPL_DATA_ACK;
                    if (w_seq == r_expected) begin
                        // In order: deliver, ack, advance
                        n_expected          = r_expected + SEQ_WIDTH'(1);
                        n_last              = w_seq;
                        w_res.reply_seq     = PKT_SEQ_W'(w_seq);
                        w_res.deliver_valid = 1'b1;
                        w_res.deliver_data  = i_item.pkt_data;
                    end else begin
                        // Out of order: re-ack the last in-order sequence (expected - 1)
                        w_res.reply_seq = PKT_SEQ_W'(r_expected - SEQ_WIDTH'(1));
                    end
                end else if (i_item.frame_type == PKT_FIN && r_syn_seen) begin
                    w_res.send_valid = 1'b1;
                    w_res.reply_kind = RPL_FIN_ACK;
                    w_res.reply_seq  = i_item.pkt_seq & PKT_SEQ_W'({SEQ_WIDTH{1'b1}});
                    n_fin_seen       = 1'b1;
                end
            end

            w_res.link_closed = n_closed;
        end
    end

    assign o_result = w_res;

    // Close-wait limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_limit <= CLOSE_WAIT_RESET;
        end else if (i_cfg_wen) begin
            r_close_limit <= i_cfg_wdata;
        end
    end

    // Commit state when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= '0;
            r_expected    <= '0;
            r_syn_seen    <= 1'b0;
            r_link_up     <= 1'b0;
            r_fin_seen    <= 1'b0;
            r_close_count <= '0;
            r_closed      <= 1'b0;
        end else if (i_fire) begin
            r_last        <= n_last;
            r_expected    <= n_expected;
            r_syn_seen    <= n_syn_seen;
            r_link_up     <= n_link_up;
            r_fin_seen    <= n_fin_seen;
            r_close_count <= n_close_count;
            r_closed      <= n_closed;
        end
    end

    // Closure is final
    `GBN_ASSERT(a_closed_sticky, r_closed |=> r_closed, "link reopened after close")
    // The close timer only runs once FIN has been taken
    `GBN_ASSERT(a_count_needs_fin, !r_fin_seen |-> (r_close_count == '0),
                "close counter moved before FIN")
    // A delivered word always comes with its DATA_ACK
    `GBN_ASSERT(a_deliver_acked,
                (i_fire && w_res.deliver_valid) |->
                    (w_res.send_valid && w_res.reply_kind == RPL_DATA_ACK),
                "delivery without data ack")
    // Closing requires FIN to have been seen
    `GBN_ASSERT(a_close_after_fin, r_closed |-> r_fin_seen, "closed without FIN")

endmodule

FILE: rtl/gbn_out_reg.sv
// Result register stage: holds one result beat until the sink takes it.
module gbn_out_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  gbn_pkg::t_result                 i_result,
    output logic                             o_advance,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [gbn_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic [gbn_pkg::OUT_TUSER_W-1:0]  o_tuser
);
    import gbn_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Room for a new result when empty or when the held one leaves now
    assign o_advance = !r_valid || i_tready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // Pack the beat
    assign o_tvalid = r_valid;
    assign o_tdata  = {r_result.deliver_data, r_result.reply_seq};
    assign o_tuser  = {r_result.link_closed, r_result.deliver_valid,
                       r_result.reply_kind, r_result.send_valid};

endmodule

FILE: rtl/go_back_n_receiver_core.sv
// Top level of the go-back-N receiver: input stage, protocol logic, result stage.
//
//  Channel   Dir  Handshake             Contents
//  s_axis    in   tvalid/tready         tdata: pkt_seq, pkt_data; tuser: op, frame_type
//  m_axis    out  tvalid/tready         tdata: reply_seq, deliver_data;
//                                       tuser: send_valid, reply_kind, deliver_valid,
//                                              link_closed
//  cfg       in   write enable          close_wait_limit (16 bit)
//
// One item per cycle sustained while m_axis takes every beat; a beat accepted into the
// input register is processed from there and loaded into the result register,
// from which m_axis takes it.
// The rate is set by the state update in the protocol logic, committed once per item.
// Reset is synchronous, active low; it clears link state, both stages, and loads
// the close-wait limit with 1000. A stalled m_axis holds its beat, the input
// register fills once, then s_axis_tready drops in the same cycle.
module go_back_n_receiver_core #(
    parameter int unsigned SEQ_WIDTH = gbn_pkg::SEQ_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_wen,
    input  logic [gbn_pkg::CLOSE_W-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] pkt_seq, [63:32] pkt_data
    input  logic [gbn_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] op, [3:1] frame_type
    input  logic [gbn_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] reply_seq, [63:32] deliver_data
    output logic [gbn_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] send_valid, [2:1] reply_kind, [3] deliver_valid, [4] link_closed
    output logic [gbn_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser
);
    import gbn_pkg::*;

    logic     w_advance;
    logic     w_fire;
    t_in_item w_item;
    t_result  w_result;

    gbn_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .i_advance (w_advance),
        .o_fire    (w_fire),
        .o_item    (w_item)
    );

    gbn_proto #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_proto (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    gbn_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_fire),
        .i_result  (w_result),
        .o_advance (w_advance),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser)
    );

endmodule
